// File: rtl/psd_pkg.sv
// Shared widths, types and codes for the point to segment distance pipeline.
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

  localparam int CW          = 16;             // coordinate width, Q11.4
  localparam int DW          = CW + 1;         // coordinate difference width
  localparam int PW          = 2 * DW;         // product of two differences
  localparam int LW          = PW;             // squared length / remainder width
  localparam int DOTW        = PW + 1;         // dot product width, signed
  localparam int TFRAC       = 16;             // fraction bits of t
  localparam int TW          = TFRAC + 1;      // t runs 0 .. 1.0
  localparam int OW          = DW + TW + 1;    // offset P - C, 20 fraction bits, signed
  localparam int MW          = OW - 1;         // offset magnitude
  localparam int HW          = MW / 2;         // half of a magnitude for split squares
  localparam int SSW         = 2 * MW;         // one squared offset
  localparam int SQW         = SSW + 1;        // sum of two squared offsets
  localparam int SQ_SHIFT    = 32;             // drop 32 fraction bits before the root
  localparam int VW          = 34;             // root input width
  localparam int RW          = VW / 2;         // root width
  localparam int RMW         = RW + 2;         // root remainder width
  localparam int DIV_STEPS   = TFRAC;
  localparam int SQRT_STEPS  = RW;
  localparam logic [TW-1:0] T_ONE    = TW'(1) << TFRAC;
  localparam logic [RW-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    TM_DIV,
    TM_ZERO,
    TM_FULL
  } tmode_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
  } psd_vec_t;

  typedef struct packed {
    psd_vec_t        vec;
    logic [LW-1:0]   len2;
    logic [LW-1:0]   rem;
    logic [TW-1:0]   t;
    tmode_t          mode;
  } psd_div_t;

  typedef struct packed {
    logic [VW-1:0]   v;
    logic            sat;
  } psd_sq_t;

  typedef struct packed {
    logic [VW-1:0]   v;
    logic [RMW-1:0]  rem;
    logic [RW-1:0]   root;
    logic            sat;
  } psd_root_t;

endpackage
`default_nettype wire

// File: rtl/psd_front.sv
// Front end: differences, dot product, squared length and clamp decision.
`timescale 1ns / 1ps
`default_nettype none
module psd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [psd_pkg::CW-1:0] point_x,
  input  wire logic signed [psd_pkg::CW-1:0] point_y,
  input  wire logic signed [psd_pkg::CW-1:0] start_x,
  input  wire logic signed [psd_pkg::CW-1:0] start_y,
  input  wire logic signed [psd_pkg::CW-1:0] end_x,
  input  wire logic signed [psd_pkg::CW-1:0] end_y,
  output logic                             out_valid,
  output psd_pkg::psd_div_t                out_item
);
  import psd_pkg::*;

  logic                 vld1_r, vld2_r, vld3_r;
  psd_vec_t             vec1_r, vec1_nxt, vec2_r;
  logic signed [PW-1:0] dxx_r, dyy_r, qdx_r, qdy_r;
  psd_div_t             item3_r, item3_nxt;

  logic [LW-1:0]        len2;
  logic [DOTW-1:0]      dot;

  always_comb begin
    vec1_nxt.dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    vec1_nxt.dy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    vec1_nxt.qx = {point_x[CW-1], point_x} - {start_x[CW-1], start_x};
    vec1_nxt.qy = {point_y[CW-1], point_y} - {start_y[CW-1], start_y};
  end

  always_comb begin
    len2 = $unsigned(dxx_r) + $unsigned(dyy_r);
    dot  = {qdx_r[PW-1], qdx_r} + {qdy_r[PW-1], qdy_r};
    item3_nxt.vec  = vec2_r;
    item3_nxt.len2 = len2;
    item3_nxt.t    = '0;
    item3_nxt.rem  = '0;
    if (len2 == '0 || dot[DOTW-1] || dot == '0) begin
      item3_nxt.mode = TM_ZERO;
    end else if (dot >= {1'b0, len2}) begin
      item3_nxt.mode = TM_FULL;
    end else begin
      item3_nxt.mode = TM_DIV;
      item3_nxt.rem  = dot[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1_r  <= vec1_nxt;
      vec2_r  <= vec1_r;
      dxx_r   <= $signed(vec1_r.dx) * $signed(vec1_r.dx);
      dyy_r   <= $signed(vec1_r.dy) * $signed(vec1_r.dy);
      qdx_r   <= $signed(vec1_r.qx) * $signed(vec1_r.dx);
      qdy_r   <= $signed(vec1_r.qy) * $signed(vec1_r.dy);
      item3_r <= item3_nxt;
    end
  end

  assign out_valid = vld3_r;
  assign out_item  = item3_r;

endmodule
`default_nettype wire

// File: rtl/psd_div.sv
// Restoring divider for t, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module psd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  psd_pkg::psd_div_t      in_item,
  output logic                   out_valid,
  output psd_pkg::psd_div_t      out_item
);
  import psd_pkg::*;

  psd_div_t               stg_r [DIV_STEPS];
  logic [DIV_STEPS-1:0]   vld_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    psd_div_t      src;
    psd_div_t      stg_nxt;
    logic          vld_src;
    logic [LW:0]   shl;
    logic          ge;

    if (k == 0) begin : g_first
      assign src     = in_item;
      assign vld_src = in_valid;
    end else begin : g_next
      assign src     = stg_r[k-1];
      assign vld_src = vld_r[k-1];
    end

    assign shl = {src.rem, 1'b0};
    assign ge  = shl >= {1'b0, src.len2};

    always_comb begin
      stg_nxt      = src;
      stg_nxt.rem  = ge ? LW'(shl - {1'b0, src.len2}) : shl[LW-1:0];
      stg_nxt.t    = {src.t[TW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_item  = stg_r[DIV_STEPS-1];

`ifndef SYNTH
  a_rem_below_len2: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DIV_STEPS-1] && stg_r[DIV_STEPS-1].mode == TM_DIV
      |-> stg_r[DIV_STEPS-1].rem < stg_r[DIV_STEPS-1].len2)
    else $error("divider remainder not below squared length");
  a_div_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_item.mode == TM_DIV
      |-> in_item.rem != '0 && in_item.rem < in_item.len2)
    else $error("divide mode entered with dot product out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/psd_dist.sv
// Nearest point offset and squared distance, split into narrow multiplies.
`timescale 1ns / 1ps
`default_nettype none
module psd_dist (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  psd_pkg::psd_div_t      in_item,
  output logic                   out_valid,
  output psd_pkg::psd_sq_t       out_item
);
  import psd_pkg::*;

  logic [4:0]            vld_r;

  logic [TW-1:0]         t_eff;
  logic signed [TW:0]    ts;
  logic signed [OW-1:0]  tdx_r, tdy_r;
  logic signed [DW-1:0]  qx_r, qy_r;

  logic signed [OW-1:0]  qsx, qsy, ox, oy;
  logic [MW-1:0]         magx_r, magy_r;

  logic [2*HW-1:0]       xhh_r, xhl_r, xll_r, yhh_r, yhl_r, yll_r;
  logic [SSW-1:0]        x2_r, y2_r;
  logic [SQW-1:0]        ssum;
  psd_sq_t               sq_r, sq_nxt;

  always_comb begin
    case (in_item.mode)
      TM_ZERO: t_eff = '0;
      TM_FULL: t_eff = T_ONE;
      default: t_eff = in_item.t;
    endcase
    ts = $signed({1'b0, t_eff});
  end

  always_comb begin
    qsx = {{(OW-DW-TFRAC){qx_r[DW-1]}}, qx_r, {TFRAC{1'b0}}};
    qsy = {{(OW-DW-TFRAC){qy_r[DW-1]}}, qy_r, {TFRAC{1'b0}}};
    ox  = qsx - tdx_r;
    oy  = qsy - tdy_r;
  end

  always_comb begin
    ssum       = {1'b0, x2_r} + {1'b0, y2_r};
    sq_nxt.v   = ssum[VW+SQ_SHIFT-1:SQ_SHIFT];
    sq_nxt.sat = |ssum[SQW-1:VW+SQ_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tdx_r  <= ts * $signed(in_item.vec.dx);
      tdy_r  <= ts * $signed(in_item.vec.dy);
      qx_r   <= in_item.vec.qx;
      qy_r   <= in_item.vec.qy;
      magx_r <= ox[OW-1] ? MW'(-ox) : ox[MW-1:0];
      magy_r <= oy[OW-1] ? MW'(-oy) : oy[MW-1:0];
      xhh_r  <= magx_r[MW-1:HW] * magx_r[MW-1:HW];
      xhl_r  <= magx_r[MW-1:HW] * magx_r[HW-1:0];
      xll_r  <= magx_r[HW-1:0] * magx_r[HW-1:0];
      yhh_r  <= magy_r[MW-1:HW] * magy_r[MW-1:HW];
      yhl_r  <= magy_r[MW-1:HW] * magy_r[HW-1:0];
      yll_r  <= magy_r[HW-1:0] * magy_r[HW-1:0];
      // (h*2^HW + l)^2 = hh*2^(2HW) + 2*hl*2^HW + ll
      x2_r   <= (SSW'(xhh_r) << (2*HW)) + (SSW'(xhl_r) << (HW+1)) + SSW'(xll_r);
      y2_r   <= (SSW'(yhh_r) << (2*HW)) + (SSW'(yhl_r) << (HW+1)) + SSW'(yll_r);
      sq_r   <= sq_nxt;
    end
  end

  assign out_valid = vld_r[4];
  assign out_item  = sq_r;

endmodule
`default_nettype wire

// File: rtl/psd_sqrt.sv
// Floor square root, one result bit per pipeline stage, with saturation.
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  psd_pkg::psd_sq_t           in_item,
  output logic                       out_valid,
  output logic [psd_pkg::RW-1:0]     out_distance
);
  import psd_pkg::*;

  psd_root_t               stg_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]   vld_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    psd_root_t       src;
    psd_root_t       stg_nxt;
    logic            vld_src;
    logic [RMW+1:0]  cat;
    logic [RMW-1:0]  trial;
    logic            ge;

    if (k == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.v    = in_item.v;
        src.sat  = in_item.sat;
      end
      assign vld_src = in_valid;
    end else begin : g_next
      assign src     = stg_r[k-1];
      assign vld_src = vld_r[k-1];
    end

    assign cat   = {src.rem, src.v[2*(SQRT_STEPS-1-k) +: 2]};
    assign trial = {src.root, 2'b01};
    assign ge    = cat >= {2'b00, trial};

    always_comb begin
      stg_nxt      = src;
      stg_nxt.rem  = ge ? RMW'(cat - {2'b00, trial}) : cat[RMW-1:0];
      stg_nxt.root = {src.root[RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign out_valid    = vld_r[SQRT_STEPS-1];
  assign out_distance = stg_r[SQRT_STEPS-1].sat ? DIST_MAX : stg_r[SQRT_STEPS-1].root;

`ifndef SYNTH
  a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_STEPS-1]
      |-> stg_r[SQRT_STEPS-1].rem <= {1'b0, stg_r[SQRT_STEPS-1].root, 1'b0})
    else $error("square root remainder exceeds twice the root");
`endif

endmodule
`default_nettype wire

// File: rtl/point_segment_distance_2d_core.sv
// Top level of the point to segment distance pipeline.
// Usage:
//   Input channel in_valid/in_ready carries a query point and the two segment
//   endpoints, signed Q11.4. Result channel out_valid/out_ready carries the
//   floor Euclidean distance to the nearest segment point, unsigned Q13.4,
//   saturated at all ones.
//   The pipeline has 3 front stages (differences, products, sums and clamp),
//   16 divider stages (one bit of t each), 5 stages for the offset and its
//   square, 17 root stages (one result bit each). Throughput is one beat per
//   cycle while the receiver does not stall; every stage holds its own valid bit.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated. Bubbles in the pipeline
//   do not squeeze out while the output stalls.
//   Synchronous active-low reset clears all valid bits; the data registers have
//   no reset, and the pipeline is ready once reset is released.
//   A zero-length segment gives the distance to its first endpoint.
`timescale 1ns / 1ps
`default_nettype none
module point_segment_distance_2d_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [psd_pkg::CW-1:0] in_point_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_point_y,
  input  wire logic signed [psd_pkg::CW-1:0] in_start_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_start_y,
  input  wire logic signed [psd_pkg::CW-1:0] in_end_x,
  input  wire logic signed [psd_pkg::CW-1:0] in_end_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [psd_pkg::RW-1:0]             out_distance
);
  import psd_pkg::*;

  logic      en;
  logic      front_vld, div_vld, dist_vld;
  psd_div_t  front_item, div_item;
  psd_sq_t   dist_item;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .out_valid (front_vld),
    .out_item  (front_item)
  );

  psd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_vld),
    .in_item   (front_item),
    .out_valid (div_vld),
    .out_item  (div_item)
  );

  psd_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_vld),
    .in_item   (div_item),
    .out_valid (dist_vld),
    .out_item  (dist_item)
  );

  psd_sqrt u_sqrt (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (dist_vld),
    .in_item      (dist_item),
    .out_valid    (out_valid),
    .out_distance (out_distance)
  );

endmodule
`default_nettype wire

// File: test/point_segment_distance_2d_core_test.sv
// Self-checking bench for the point to segment distance pipeline: random and corner queries.
`timescale 1ns / 1ps
`default_nettype none

class dist_board;
  int unsigned errors;
  logic [16:0] pending[$];

  // exact distance: t from restoring division, offsets at 20 fraction bits, floor root
  function logic [16:0] distance_of(logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] sx, logic signed [15:0] sy, logic signed [15:0] ex,
      logic signed [15:0] ey);
    longint dx, dy, qx, qy, len2, dot, t, rem, ox, oy;
    longint unsigned ax, ay;
    logic [127:0] s;
    logic [63:0] v, r, b;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    qx = longint'(px) - longint'(sx);
    qy = longint'(py) - longint'(sy);
    len2 = dx * dx + dy * dy;
    dot = qx * dx + qy * dy;
    t = 0;
    if (len2 == 0 || dot <= 0) t = 0;
    else if (dot >= len2) t = 65536;
    else begin
      rem = dot;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= len2) begin
          rem = rem - len2;
          t = t | 1;
        end
      end
    end
    ox = qx * 65536 - t * dx;
    oy = qy * 65536 - t * dy;
    // squares of full-scale offsets reach 2^64, so square the magnitudes at 128 bits
    ax = (ox < 0) ? -ox : ox;
    ay = (oy < 0) ? -oy : oy;
    s = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    v = 64'(s >> 32);
    if (v >= (64'd1 << 34)) return 17'h1ffff;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    if (r > 64'h1ffff) return 17'h1ffff;
    return r[16:0];
  endfunction

  function void note_query(logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] sx, logic signed [15:0] sy, logic signed [15:0] ex,
      logic signed [15:0] ey);
    pending.push_back(distance_of(px, py, sx, sy, ex, ey));
  endfunction

  function void check_distance(logic [16:0] got);
    logic [16:0] want;
    if (pending.size() == 0) begin
      report_bad($sformatf("result beat %0d with nothing pending", got));
      return;
    end
    want = pending.pop_front();
    if (got !== want) report_bad($sformatf("distance %0d, want %0d", got, want));
  endfunction

  function void report_bad(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endfunction
endclass

module point_segment_distance_2d_core_test;
  import psd_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic signed [CW-1:0] in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y;
  logic [RW-1:0] out_distance;
  int unsigned cycles;
  bit hold_off;
  dist_board board;

  point_segment_distance_2d_core i_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) board.check_distance(out_distance);

  // receiver stall pattern, plus one long hold-off
  initial begin
    int phase;
    out_ready = 0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) out_ready <= 0;
      else if (phase % 500 < 150) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    hold_off = 0;
    wait (cycles == 600);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  function automatic logic signed [15:0] pick_coord(int shape);
    case (shape)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 31)) - 16'sd16;
      3: return 16'($urandom_range(0, 2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_query(logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] sx, logic signed [15:0] sy, logic signed [15:0] ex,
      logic signed [15:0] ey);
    in_valid <= 1;
    in_point_x <= px; in_point_y <= py;
    in_start_x <= sx; in_start_y <= sy;
    in_end_x <= ex; in_end_y <= ey;
    do @(posedge clk); while (!in_ready);
    board.note_query(px, py, sx, sy, ex, ey);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] sx, sy;
    int burst;
    board = new();
    rst_n = 0;
    in_valid = 0;
    {in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // corners: zero length, before start, past end, interior, full-scale extremes
    send_query(0, 0, 0, 0, 0, 0);
    send_query(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_query(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_query(-100, 0, 0, 0, 100, 0);
    send_query(300, 50, 0, 0, 100, 0);
    send_query(50, 77, 0, 0, 100, 0);
    send_query(0, 0, 0, 0, 0, 0);
    send_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_query(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_query(0, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 0);
    send_query(16'sh8000, 16'sh8000, 0, 0, 0, 1);
    send_query(16'sh7fff, 16'sh7fff, 1, 0, 0, 0);
    send_query(5, 5, 5, 5, 5, 5);
    send_query(-1, -1, 0, 0, 1, 1);
    send_query(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555, 16'sh5555);
    for (int n = 0; n < 1550;) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++) begin
        sx = pick_coord($urandom_range(0, 6));
        sy = pick_coord($urandom_range(0, 6));
        if ($urandom_range(0, 15) == 0) send_query(pick_coord($urandom_range(0, 6)),
            pick_coord($urandom_range(0, 6)), sx, sy, sx, sy);
        else send_query(pick_coord($urandom_range(0, 6)), pick_coord($urandom_range(0, 6)),
            sx, sy, pick_coord($urandom_range(0, 6)), pick_coord($urandom_range(0, 6)));
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_div.sv
rtl/psd_dist.sv
rtl/psd_sqrt.sv
rtl/point_segment_distance_2d_core.sv
test/point_segment_distance_2d_core_test.sv
